// ----- hw/rtl/sbeq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo biquad EQ package
// Shared widths, codes, arithmetic types and controller/datapath bundles.
// ----------------------------------------------------------------------------
package sbeq_pkg;

   // Arithmetic widths
   localparam int DATA_BITS      = 32;   // between-band sample and coefficient
   localparam int PROD_BITS      = 64;   // one coefficient product
   localparam int ACC_BITS       = 67;   // sum of five products, exact
   localparam int FRAC_BITS      = 28;   // Q4.28 coefficients

   // Field widths
   localparam int ACTION_BITS    = 2;
   localparam int BAND_BITS      = 3;
   localparam int BAND_CNT_BITS  = 4;    // band counter, holds the band count too
   localparam int SEL_BITS       = 3;
   localparam int STEP_BITS      = 3;
   localparam int SLOT_BITS      = 2;
   localparam int MASK_BITS      = 8;
   localparam int INDEX_BITS     = 6;    // full store index before trimming

   localparam int COEFS_PER_BAND = 5;
   localparam int HIST_PER_BAND  = 8;

   typedef logic signed [DATA_BITS-1:0] data_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;

   // Transaction actions
   localparam logic [ACTION_BITS-1:0] ACT_SAMPLE = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_LOAD   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd2;

   // MAC steps, same order as the coefficient select codes
   localparam logic [STEP_BITS-1:0] STEP_B0 = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_B1 = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_B2 = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_A1 = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_A2 = 3'd4;

   // History slots within one channel of one band
   localparam logic [SLOT_BITS-1:0] SLOT_X1 = 2'd0;
   localparam logic [SLOT_BITS-1:0] SLOT_X2 = 2'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_Y1 = 2'd2;
   localparam logic [SLOT_BITS-1:0] SLOT_Y2 = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic                  start;    // sample accepted: load working values
      logic                  load;     // coefficient load accepted
      logic                  clear;    // history clear accepted
      logic                  issue;    // start one MAC step
      logic [BAND_BITS-1:0]  band;
      logic                  chan;     // 0 left, 1 right
      logic [STEP_BITS-1:0]  step;
      logic                  publish;  // move the finished sample to the output
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic busy;       // MAC pipeline holds steps
      logic out_free;   // output register can take a result this cycle
   } status_type;

   // Bands that can filter: the mask and the band index cover eight
   function automatic int active_bands(input int bands);
      return (bands < MASK_BITS) ? bands : MASK_BITS;
   endfunction

   function automatic logic [INDEX_BITS-1:0] coef_index(
      input logic [BAND_BITS-1:0] band,
      input logic [SEL_BITS-1:0]  sel
   );
      logic [INDEX_BITS-1:0] b;
      b = INDEX_BITS'(band);
      return (b << 2) + b + INDEX_BITS'(sel);
   endfunction

   function automatic logic [INDEX_BITS-1:0] hist_index(
      input logic [BAND_BITS-1:0] band,
      input logic                 chan,
      input logic [SLOT_BITS-1:0] slot
   );
      return {band, chan, slot};
   endfunction

   // History slot that a MAC step reads
   function automatic logic [SLOT_BITS-1:0] read_slot(input logic [STEP_BITS-1:0] step);
      logic [SLOT_BITS-1:0] s;
      case (step)
         STEP_B1: s = SLOT_X1;
         STEP_B2: s = SLOT_X2;
         STEP_A1: s = SLOT_Y1;
         STEP_A2: s = SLOT_Y2;
         default: s = SLOT_X1;
      endcase
      return s;
   endfunction

endpackage

// ----- hw/rtl/sbeq_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo biquad EQ request channel
// Valid/ready channel carrying samples, coefficient loads and history clears.
// ----------------------------------------------------------------------------
interface sbeq_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                                       valid;
   logic                                       ready;
   logic [sbeq_pkg::ACTION_BITS-1:0]           action;
   logic signed [SAMPLE_BITS-1:0]              left_in;
   logic signed [SAMPLE_BITS-1:0]              right_in;
   logic [sbeq_pkg::BAND_BITS-1:0]             band_index;
   logic [sbeq_pkg::SEL_BITS-1:0]              coef_select;
   logic signed [sbeq_pkg::DATA_BITS-1:0]      coef_value;

   modport source (
      output valid, action, left_in, right_in, band_index, coef_select, coef_value,
      input  ready
   );

   modport sink (
      input  valid, action, left_in, right_in, band_index, coef_select, coef_value,
      output ready
   );
endinterface

// ----- hw/rtl/sbeq_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo biquad EQ response channel
// Valid/ready channel carrying equalized stereo samples and the clip flag.
// ----------------------------------------------------------------------------
interface sbeq_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic                          clipped;

   modport source (
      output valid, left_out, right_out, clipped,
      input  ready
   );

   modport sink (
      input  valid, left_out, right_out, clipped,
      output ready
   );
endinterface

// ----- hw/rtl/sbeq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo biquad EQ generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbeq_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 40,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sbeq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo biquad EQ controller
// Accepts transactions, holds the band enable mask and steps the MAC datapath
// through every enabled band, left then right, five steps per channel.
// ----------------------------------------------------------------------------
module sbeq_ctrl #(
   parameter int BANDS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sbeq_pkg::ACTION_BITS-1:0]  req_action,
   input  logic                              csr_we,
   input  logic [sbeq_pkg::MASK_BITS-1:0]    csr_wdata,
   input  sbeq_pkg::status_type              status,
   output sbeq_pkg::cmd_type                 cmd
);

   localparam int ACT_BANDS = sbeq_pkg::active_bands(BANDS);
   localparam logic [sbeq_pkg::BAND_CNT_BITS-1:0] BAND_END =
      sbeq_pkg::BAND_CNT_BITS'(ACT_BANDS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                             state_ff, state_in;
   logic [sbeq_pkg::BAND_CNT_BITS-1:0]     band_ff, band_in;
   logic                                   chan_ff, chan_in;
   logic [sbeq_pkg::STEP_BITS-1:0]         step_ff, step_in;
   logic [sbeq_pkg::MASK_BITS-1:0]         mask_ff, mask_in;
   logic                                   accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign mask_in   = csr_we ? csr_wdata : mask_ff;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      band_in     = band_ff;
      chan_in     = chan_ff;
      step_in     = step_ff;
      cmd         = '0;
      cmd.band    = band_ff[sbeq_pkg::BAND_BITS-1:0];
      cmd.chan    = chan_ff;
      cmd.step    = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  sbeq_pkg::ACT_SAMPLE: begin
                     cmd.start = 1'b1;
                     band_in   = '0;
                     chan_in   = 1'b0;
                     step_in   = sbeq_pkg::STEP_B0;
                     state_in  = ST_RUN;
                  end
                  sbeq_pkg::ACT_LOAD:  cmd.load  = 1'b1;
                  sbeq_pkg::ACT_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (band_ff == BAND_END) begin
               state_in = ST_DRAIN;
            end else if (!mask_ff[band_ff[sbeq_pkg::BAND_BITS-1:0]]) begin
               // passthrough band: history untouched
               band_in = band_ff + 1'b1;
            end else begin
               cmd.issue = 1'b1;
               if (step_ff == sbeq_pkg::STEP_A2) begin
                  step_in = sbeq_pkg::STEP_B0;
                  if (chan_ff) begin
                     chan_in = 1'b0;
                     band_in = band_ff + 1'b1;
                  end else begin
                     chan_in = 1'b1;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.busy && status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         band_ff  <= '0;
         chan_ff  <= 1'b0;
         step_ff  <= sbeq_pkg::STEP_B0;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         chan_ff  <= chan_in;
         step_ff  <= step_in;
         mask_ff  <= mask_in;
      end
   end

endmodule

// ----- hw/rtl/sbeq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo biquad EQ datapath
// Coefficient and history RAMs with per-entry valid bits, one 32x32 MAC
// pipeline (read, multiply, accumulate, finalize), working sample registers
// and the output register.
// ----------------------------------------------------------------------------
module sbeq_datapath #(
   parameter int BANDS       = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sbeq_pkg::cmd_type                      cmd,
   output sbeq_pkg::status_type                   status,
   input  logic signed [SAMPLE_BITS-1:0]          req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]          req_right_in,
   input  logic [sbeq_pkg::BAND_BITS-1:0]         req_band_index,
   input  logic [sbeq_pkg::SEL_BITS-1:0]          req_coef_select,
   input  logic signed [sbeq_pkg::DATA_BITS-1:0]  req_coef_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]          rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]          rsp_right_out,
   output logic                                   rsp_clipped
);

   localparam int ACT_BANDS  = sbeq_pkg::active_bands(BANDS);
   localparam int COEF_DEPTH = ACT_BANDS * sbeq_pkg::COEFS_PER_BAND;
   localparam int HIST_DEPTH = ACT_BANDS * sbeq_pkg::HIST_PER_BAND;
   localparam int CA_BITS    = $clog2(COEF_DEPTH);
   localparam int HA_BITS    = $clog2(HIST_DEPTH);
   localparam int DW         = sbeq_pkg::DATA_BITS;
   localparam int IW         = sbeq_pkg::INDEX_BITS;
   localparam int TOP_LSB    = sbeq_pkg::FRAC_BITS + DW - 1;

   // ---------------- stores ----------------
   logic [CA_BITS-1:0]          coef_wr_addr, coef_rd_addr;
   logic                        coef_we;
   logic [DW-1:0]               coef_rd_data;
   logic [HA_BITS-1:0]          hist_wr_addr, hist_rd_addr;
   logic                        hist_we;
   sbeq_pkg::data_type          hist_wr_data;
   logic [DW-1:0]               hist_rd_data;
   logic [COEF_DEPTH-1:0]       coef_vld_ff, coef_vld_in;
   logic [HIST_DEPTH-1:0]       hist_vld_ff, hist_vld_in;
   logic                        band_ok;

   // ---------------- pipeline ----------------
   logic                              s1_v_ff, s2_v_ff, s3_v_ff;
   logic [sbeq_pkg::BAND_BITS-1:0]    s1_band_ff, s2_band_ff, s3_band_ff;
   logic                              s1_chan_ff, s2_chan_ff, s3_chan_ff;
   logic [sbeq_pkg::STEP_BITS-1:0]    s1_step_ff, s2_step_ff, s3_step_ff;
   logic                              cvld_s1_ff, hvld_s1_ff;
   sbeq_pkg::data_type                coef_op, val_op, x_op, hold_in, hold_ff;
   sbeq_pkg::prod_type                prod_in, prod_ff, addend;
   sbeq_pkg::acc_type                 acc_in, acc_ff, acc_base;

   // ---------------- working values ----------------
   sbeq_pkg::data_type                cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic                              clip_ff, clip_in;
   logic [sbeq_pkg::ACC_BITS-TOP_LSB-1:0] y_top;
   logic                              y_ok, y_fin;
   sbeq_pkg::data_type                y_val;
   logic                              s2_wr, s3_wr;
   logic [sbeq_pkg::SLOT_BITS-1:0]    s2_slot;

   // ---------------- output ----------------
   logic                              rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]     rsp_left_ff, rsp_right_ff, out_l, out_r;
   logic                              rsp_clip_ff, sat_l, sat_r;
   logic [DW-SAMPLE_BITS:0]           l_top, r_top;

   assign band_ok = {1'b0, req_band_index} < sbeq_pkg::BAND_CNT_BITS'(ACT_BANDS);

   // coefficient store: written by load transactions, read by MAC steps
   assign coef_we      = cmd.load && band_ok && (req_coef_select <= sbeq_pkg::STEP_A2);
   assign coef_wr_addr = CA_BITS'(sbeq_pkg::coef_index(req_band_index, req_coef_select));
   assign coef_rd_addr = CA_BITS'(sbeq_pkg::coef_index(cmd.band, cmd.step));

   sbeq_ram #(.WIDTH(DW), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_wr_addr),
      .wr_data (req_coef_value),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   assign hist_rd_addr = HA_BITS'(sbeq_pkg::hist_index(cmd.band, cmd.chan,
                                                        sbeq_pkg::read_slot(cmd.step)));

   sbeq_ram #(.WIDTH(DW), .DEPTH(HIST_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // valid bits: an entry never written reads as zero
   always_comb begin
      logic [IW-1:0] ent;
      coef_vld_in = coef_vld_ff;
      hist_vld_in = hist_vld_ff;
      ent         = '0;
      if (coef_we) begin
         coef_vld_in[coef_wr_addr] = 1'b1;
      end
      if (cmd.clear && band_ok) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            ent = IW'(i);
            if (ent[IW-1:sbeq_pkg::SLOT_BITS+1] == req_band_index) begin
               hist_vld_in[i] = 1'b0;
            end
         end
      end
      if (hist_we) begin
         hist_vld_in[hist_wr_addr] = 1'b1;
      end
   end

   // stage 1: operands from the stores, multiply
   assign x_op    = s1_chan_ff ? cur_r_ff : cur_l_ff;
   assign coef_op = cvld_s1_ff ? sbeq_pkg::data_type'(coef_rd_data) : '0;
   assign val_op  = (s1_step_ff == sbeq_pkg::STEP_B0) ? x_op :
                    (hvld_s1_ff ? sbeq_pkg::data_type'(hist_rd_data) : '0);
   assign prod_in = sbeq_pkg::prod_type'(coef_op) * sbeq_pkg::prod_type'(val_op);
   // value that the step shifts along in the history
   assign hold_in = (s1_step_ff == sbeq_pkg::STEP_B2) ? x_op : val_op;

   // stage 2: accumulate, a1/a2 terms subtract
   assign addend   = prod_ff;
   assign acc_base = (s2_step_ff == sbeq_pkg::STEP_B0) ? '0 : acc_ff;
   assign acc_in   = ((s2_step_ff == sbeq_pkg::STEP_A1) || (s2_step_ff == sbeq_pkg::STEP_A2))
                     ? acc_base - sbeq_pkg::acc_type'(addend)
                     : acc_base + sbeq_pkg::acc_type'(addend);

   // stage 3: floor shift by the fraction bits and saturate to 32 bits
   assign y_top = acc_ff[sbeq_pkg::ACC_BITS-1:TOP_LSB];
   assign y_ok  = (&y_top) || !(|y_top);
   assign y_val = y_ok ? acc_ff[TOP_LSB:sbeq_pkg::FRAC_BITS]
                       : {acc_ff[sbeq_pkg::ACC_BITS-1], {(DW-1){~acc_ff[sbeq_pkg::ACC_BITS-1]}}};
   assign y_fin = s3_v_ff && (s3_step_ff == sbeq_pkg::STEP_A2);

   // history writes: x1->x2, x->x1, y1->y2 from stage 2, y->y1 from stage 3
   always_comb begin
      case (s2_step_ff)
         sbeq_pkg::STEP_B1: s2_slot = sbeq_pkg::SLOT_X2;
         sbeq_pkg::STEP_B2: s2_slot = sbeq_pkg::SLOT_X1;
         sbeq_pkg::STEP_A1: s2_slot = sbeq_pkg::SLOT_Y2;
         default:           s2_slot = sbeq_pkg::SLOT_X1;
      endcase
   end

   assign s2_wr = s2_v_ff && ((s2_step_ff == sbeq_pkg::STEP_B1) ||
                              (s2_step_ff == sbeq_pkg::STEP_B2) ||
                              (s2_step_ff == sbeq_pkg::STEP_A1));
   assign s3_wr = y_fin;
   assign hist_we      = s2_wr || s3_wr;
   assign hist_wr_addr = s3_wr
      ? HA_BITS'(sbeq_pkg::hist_index(s3_band_ff, s3_chan_ff, sbeq_pkg::SLOT_Y1))
      : HA_BITS'(sbeq_pkg::hist_index(s2_band_ff, s2_chan_ff, s2_slot));
   assign hist_wr_data = s3_wr ? y_val : hold_ff;

   // working sample values and clip flag
   always_comb begin
      cur_l_in = cur_l_ff;
      cur_r_in = cur_r_ff;
      clip_in  = clip_ff;
      if (cmd.start) begin
         cur_l_in = sbeq_pkg::data_type'(req_left_in);
         cur_r_in = sbeq_pkg::data_type'(req_right_in);
         clip_in  = 1'b0;
      end else if (y_fin) begin
         if (s3_chan_ff) begin
            cur_r_in = y_val;
         end else begin
            cur_l_in = y_val;
         end
         clip_in = clip_ff || !y_ok;
      end
   end

   // final saturation to the sample width
   assign l_top = cur_l_ff[DW-1:SAMPLE_BITS-1];
   assign r_top = cur_r_ff[DW-1:SAMPLE_BITS-1];
   assign sat_l = !((&l_top) || !(|l_top));
   assign sat_r = !((&r_top) || !(|r_top));
   assign out_l = sat_l ? {cur_l_ff[DW-1], {(SAMPLE_BITS-1){~cur_l_ff[DW-1]}}}
                        : cur_l_ff[SAMPLE_BITS-1:0];
   assign out_r = sat_r ? {cur_r_ff[DW-1], {(SAMPLE_BITS-1){~cur_r_ff[DW-1]}}}
                        : cur_r_ff[SAMPLE_BITS-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff  <= '0;
         hist_vld_ff  <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_vld_ff  <= coef_vld_in;
         hist_vld_ff  <= hist_vld_in;
         s1_v_ff      <= cmd.issue;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_band_ff <= cmd.band;
      s1_chan_ff <= cmd.chan;
      s1_step_ff <= cmd.step;
      cvld_s1_ff <= coef_vld_ff[coef_rd_addr];
      hvld_s1_ff <= hist_vld_ff[hist_rd_addr];
      s2_band_ff <= s1_band_ff;
      s2_chan_ff <= s1_chan_ff;
      s2_step_ff <= s1_step_ff;
      prod_ff    <= prod_in;
      hold_ff    <= hold_in;
      s3_band_ff <= s2_band_ff;
      s3_chan_ff <= s2_chan_ff;
      s3_step_ff <= s2_step_ff;
      acc_ff     <= acc_in;
      cur_l_ff   <= cur_l_in;
      cur_r_ff   <= cur_r_in;
      clip_ff    <= clip_in;
      if (cmd.publish) begin
         rsp_left_ff  <= out_l;
         rsp_right_ff <= out_r;
         rsp_clip_ff  <= clip_ff || sat_l || sat_r;
      end
   end

   assign status.busy     = s1_v_ff || s2_v_ff || s3_v_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;
   assign rsp_clipped   = rsp_clip_ff;

endmodule

// ----- hw/rtl/stereo_biquad_eq_cascade.sv -----
`timescale 1ns / 1ps
// Sample transaction: each enabled band runs 5 MAC steps per channel on one 32x32
// multiplier and a disabled band is skipped; then come the end check, the MAC drain
// and the output load; next accept once rsp valid is up.
// Load and clear give no response; a stalled response holds the next sample.
// Synchronous reset: mask cleared, coefficient and history valid bits cleared so the
// stores read as zero; the block takes transactions in the first cycle after reset.
// ----------------------------------------------------------------------------
// Stereo biquad EQ cascade, top level
// Controller plus MAC datapath running a direct form I biquad per enabled band.
// ----------------------------------------------------------------------------
module stereo_biquad_eq_cascade #(
   parameter int BANDS       = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   sbeq_req_if.sink                         req_ch,
   sbeq_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [sbeq_pkg::MASK_BITS-1:0]   csr_wdata
);

   sbeq_pkg::cmd_type    cmd;
   sbeq_pkg::status_type status;

   sbeq_ctrl #(.BANDS(BANDS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_action (req_ch.action),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .cmd        (cmd)
   );

   sbeq_datapath #(.BANDS(BANDS), .SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_left_in     (req_ch.left_in),
      .req_right_in    (req_ch.right_in),
      .req_band_index  (req_ch.band_index),
      .req_coef_select (req_ch.coef_select),
      .req_coef_value  (req_ch.coef_value),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_left_out    (rsp_ch.left_out),
      .rsp_right_out   (rsp_ch.right_out),
      .rsp_clipped     (rsp_ch.clipped)
   );

endmodule

// ----- hw/rtl/sbeq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo biquad EQ port checker
// Port-level properties of the EQ cascade, bound to the top level.
// ----------------------------------------------------------------------------
module sbeq_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [sbeq_pkg::ACTION_BITS-1:0] req_action,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [SAMPLE_BITS-1:0]           rsp_left_out,
   input logic [SAMPLE_BITS-1:0]           rsp_right_out,
   input logic                             rsp_clipped
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a sample transaction occupies the block: no new transaction next cycle
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == sbeq_pkg::ACT_SAMPLE) |=> !req_ready)
      else $error("ready high right after a sample transaction");

   // load, clear and unknown transactions leave the block ready
   a_cmd_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action != sbeq_pkg::ACT_SAMPLE) |=> req_ready)
      else $error("ready dropped after a non-sample transaction");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out) &&
          $stable(rsp_clipped)))
      else $error("stalled response changed");

endmodule

bind stereo_biquad_eq_cascade sbeq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sbeq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_action    (req_ch.action),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_left_out  (rsp_ch.left_out),
   .rsp_right_out (rsp_ch.right_out),
   .rsp_clipped   (rsp_ch.clipped)
);
